FILE: src/pmc_pkg.sv
// Shared constants, types and helpers for the position move controller.
package pmc_pkg;

  // Default sizes handed to the top level
  localparam int POSITION_BITS_DEF  = 24;
  localparam int GAIN_FRAC_BITS_DEF = 16;
  localparam int INTEGRAL_BITS_DEF  = 32;

  // Fixed field and register widths
  localparam int GAIN_BITS     = 24;
  localparam int ZONE_BITS     = 16;
  localparam int BAND_BITS     = 16;
  localparam int LIMIT_BITS    = 7;
  localparam int TICK_BITS     = 8;
  localparam int ELAPSED_BITS  = 26;
  localparam int POWER_BITS    = 8;
  localparam int STATUS_BITS   = 2;
  localparam int SUM_BITS      = 64;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 24;

  // Products and sums saturate at +-2^61; an operand beyond +-2^37 saturates the product
  localparam int OPERAND_SAT_BITS = 37;
  localparam logic signed [SUM_BITS-1:0] SAT_BIG = 64'sh2000_0000_0000_0000;
  localparam logic [SUM_BITS-1:0] OPERAND_LIMIT  = 64'h0000_0020_0000_0000;

  // Time limit of a move: short moves get a fixed budget, others 2 ms per count
  localparam int SHORT_MOVE_DIST = 500;
  localparam int SHORT_MOVE_MS   = 700;

  // Register reset values
  localparam logic [GAIN_BITS-1:0]  PROP_GAIN_RST  = 24'd98304;
  localparam logic [GAIN_BITS-1:0]  INTEG_GAIN_RST = 24'd262;
  localparam logic [GAIN_BITS-1:0]  DERIV_GAIN_RST = 24'd144179;
  localparam logic [ZONE_BITS-1:0]  ZONE_RST       = 16'd50;
  localparam logic [BAND_BITS-1:0]  BAND_RST       = 16'd3;
  localparam logic [LIMIT_BITS-1:0] LIMIT_RST      = 7'd127;
  localparam logic [TICK_BITS-1:0]  TICK_MS_RST    = 8'd15;

  typedef enum logic [CFG_ADDR_BITS-1:0] {
    CFG_PROP_GAIN  = 3'd0,
    CFG_INTEG_GAIN = 3'd1,
    CFG_DERIV_GAIN = 3'd2,
    CFG_ZONE       = 3'd3,
    CFG_BAND       = 3'd4,
    CFG_LIMIT      = 3'd5,
    CFG_TICK_MS    = 3'd6
  } cfg_reg_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_RUN     = 2'd0,
    ST_REACHED = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_IDLE    = 2'd3
  } status_e;

  typedef enum logic {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_e;

  // Per-result control that rides along the pipeline
  typedef struct packed {
    status_e status;
    logic    done;
  } result_ctl_t;

  // Clamp a widened sum back to +-2^61
  function automatic logic signed [SUM_BITS-1:0] clamp_big(input logic signed [SUM_BITS:0] v);
    logic signed [SUM_BITS-1:0] res;
    if (v > SAT_BIG) begin
      res = SAT_BIG;
    end else if (v < -SAT_BIG) begin
      res = -SAT_BIG;
    end else begin
      res = v[SUM_BITS-1:0];
    end
    return res;
  endfunction

endpackage

FILE: src/pmc_front.sv
// Front stage: move state, error, integral zone, end-of-move decision.
module pmc_front #(
  parameter int P = pmc_pkg::POSITION_BITS_DEF,
  parameter int I = pmc_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  pmc_pkg::opcode_e                  opcode_i,
  input  logic signed [P-1:0]               target_i,
  input  logic signed [P-1:0]               position_i,
  input  logic [pmc_pkg::ZONE_BITS-1:0]     integral_zone_i,
  input  logic [pmc_pkg::BAND_BITS-1:0]     exit_band_i,
  input  logic [pmc_pkg::TICK_BITS-1:0]     tick_ms_i,
  output logic                              valid_o,
  input  logic                              ready_i,
  output logic signed [P:0]                 err_o,
  output logic signed [I-1:0]               integ_o,
  output logic signed [P+1:0]               delta_o,
  output pmc_pkg::result_ctl_t              ctl_o
);
  import pmc_pkg::*;

  localparam int ERR_W   = P + 1;
  localparam int DELTA_W = P + 2;
  localparam int TL_W    = (P + 1 > ELAPSED_BITS) ? P + 1 : ELAPSED_BITS;
  localparam int CMP_W   = ERR_W + ZONE_BITS + 1;
  localparam int ACC_W   = ((I > ERR_W) ? I : ERR_W) + 1;

  // Move state
  logic signed [P-1:0]       goal_q, goal_d;
  logic                      heading_q, heading_d;
  logic signed [ERR_W-1:0]   last_err_q, last_err_d;
  logic signed [I-1:0]       acc_q, acc_d;
  logic [ELAPSED_BITS-1:0]   elapsed_q, elapsed_d;
  logic [TL_W-1:0]           limit_q, limit_d;
  logic                      moving_q, moving_d;

  // Stage output register
  logic                      valid_q;
  logic signed [ERR_W-1:0]   err_q, err_d;
  logic signed [I-1:0]       integ_q, integ_d;
  logic signed [DELTA_W-1:0] delta_q, delta_d;
  result_ctl_t               ctl_q, ctl_d;

  logic                      accept;
  logic [P-1:0]              tgt_abs;
  logic [TL_W-1:0]           tl_start;
  logic signed [ERR_W-1:0]   err;
  logic [ERR_W-1:0]          aerr;
  logic                      in_zone;
  logic signed [ACC_W-1:0]   acc_sum;
  logic [ACC_W-I:0]          acc_hi;
  logic signed [I-1:0]       acc_upd, acc_new;
  logic                      clear_int;
  logic signed [DELTA_W-1:0] delta;
  logic [ELAPSED_BITS:0]     ela_sum;
  logic [ELAPSED_BITS-1:0]   ela_new;
  logic signed [CMP_W-1:0]   err_c, band_c;
  logic                      reached, timeout;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  // Start: direction and time budget
  always_comb begin
    tgt_abs  = target_i[P-1] ? P'(-target_i) : P'(target_i);
    tl_start = (tgt_abs < P'(SHORT_MOVE_DIST)) ? TL_W'(SHORT_MOVE_MS) : TL_W'({tgt_abs, 1'b0});
  end

  // Tick: error, integral with zone and sign reset, elapsed time, exit checks
  always_comb begin
    err       = {goal_q[P-1], goal_q} - {position_i[P-1], position_i};
    aerr      = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
    in_zone   = {{ZONE_BITS{1'b0}}, aerr} < {{ERR_W{1'b0}}, integral_zone_i};
    acc_sum   = ACC_W'(acc_q) + ACC_W'(err);
    acc_hi    = acc_sum[ACC_W-1:I-1];
    if ((&acc_hi) || !(|acc_hi)) begin
      acc_upd = acc_sum[I-1:0];
    end else if (acc_sum[ACC_W-1]) begin
      acc_upd = {1'b1, {(I-1){1'b0}}};
    end else begin
      acc_upd = {1'b0, {(I-1){1'b1}}};
    end
    clear_int = (err == '0) || (last_err_q == '0) || (err[ERR_W-1] != last_err_q[ERR_W-1]);
    acc_new   = (clear_int || !in_zone) ? '0 : acc_upd;
    delta     = DELTA_W'(err) - DELTA_W'(last_err_q);
    ela_sum   = {1'b0, elapsed_q} + (ELAPSED_BITS+1)'(tick_ms_i);
    ela_new   = ela_sum[ELAPSED_BITS] ? '1 : ela_sum[ELAPSED_BITS-1:0];
    err_c     = CMP_W'(err);
    band_c    = $signed({{(CMP_W-BAND_BITS){1'b0}}, exit_band_i});
    reached   = heading_q ? (err_c < band_c) : (err_c > -band_c);
    timeout   = TL_W'(ela_new) > limit_q;
  end

  // Next state and stage payload
  always_comb begin
    goal_d     = goal_q;
    heading_d  = heading_q;
    last_err_d = last_err_q;
    acc_d      = acc_q;
    elapsed_d  = elapsed_q;
    limit_d    = limit_q;
    moving_d   = moving_q;
    err_d      = '0;
    integ_d    = '0;
    delta_d    = '0;
    ctl_d      = '{status: ST_RUN, done: 1'b0};
    if (opcode_i == OP_START) begin
      goal_d     = target_i;
      heading_d  = !target_i[P-1] && (target_i != '0);
      last_err_d = '0;
      acc_d      = '0;
      elapsed_d  = '0;
      limit_d    = tl_start;
      moving_d   = 1'b1;
    end else if (!moving_q) begin
      ctl_d.status = ST_IDLE;
    end else begin
      elapsed_d  = ela_new;
      acc_d      = acc_new;
      last_err_d = err;
      err_d      = err;
      integ_d    = acc_new;
      delta_d    = delta;
      if (reached) begin
        ctl_d.status = ST_REACHED;
      end else if (timeout) begin
        ctl_d.status = ST_TIMEOUT;
      end
      if (reached || timeout) begin
        ctl_d.done = 1'b1;
        moving_d   = 1'b0;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_q     <= '0;
      heading_q  <= 1'b0;
      last_err_q <= '0;
      acc_q      <= '0;
      elapsed_q  <= '0;
      limit_q    <= '0;
      moving_q   <= 1'b0;
    end else if (accept) begin
      goal_q     <= goal_d;
      heading_q  <= heading_d;
      last_err_q <= last_err_d;
      acc_q      <= acc_d;
      elapsed_q  <= elapsed_d;
      limit_q    <= limit_d;
      moving_q   <= moving_d;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Stage payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q   <= err_d;
      integ_q <= integ_d;
      delta_q <= delta_d;
      ctl_q   <= ctl_d;
    end
  end

  assign valid_o = valid_q;
  assign err_o   = err_q;
  assign integ_o = integ_q;
  assign delta_o = delta_q;
  assign ctl_o   = ctl_q;

endmodule

FILE: src/pmc_satmul.sv
// Saturating gain multiplier: unsigned Q8.16 gain times a signed operand.
module pmc_satmul #(
  parameter int W = pmc_pkg::POSITION_BITS_DEF + 1
) (
  input  logic [pmc_pkg::GAIN_BITS-1:0]       gain_i,
  input  logic signed [W-1:0]                 oper_i,
  output logic signed [pmc_pkg::SUM_BITS-1:0] prod_o
);
  import pmc_pkg::*;

  localparam int LIM_W = OPERAND_SAT_BITS + 2;
  localparam int OPW   = (W < LIM_W) ? W : LIM_W;
  localparam int EXT_W = (W > LIM_W) ? W : LIM_W;

  logic signed [EXT_W-1:0]       oper_ext;
  logic signed [EXT_W-1:0]       op_lim;
  logic signed [OPW-1:0]         oper_n;
  logic signed [GAIN_BITS:0]     gain_s;
  logic signed [GAIN_BITS+OPW:0] prod;
  logic                          over_pos, over_neg;

  // Operands past the limit saturate; inside it the product stays below 2^61
  always_comb begin
    oper_ext = EXT_W'(oper_i);
    op_lim   = $signed(EXT_W'(OPERAND_LIMIT));
    over_pos = oper_ext > op_lim;
    over_neg = oper_ext < -op_lim;
    oper_n   = oper_ext[OPW-1:0];
    gain_s   = $signed({1'b0, gain_i});
    prod     = gain_s * oper_n;
    if (gain_i == '0) begin
      prod_o = '0;
    end else if (over_pos) begin
      prod_o = SAT_BIG;
    end else if (over_neg) begin
      prod_o = -SAT_BIG;
    end else begin
      prod_o = SUM_BITS'(prod);
    end
  end

endmodule

FILE: src/pmc_mult.sv
// Multiply stage: the three gain products, registered.
module pmc_mult #(
  parameter int P = pmc_pkg::POSITION_BITS_DEF,
  parameter int I = pmc_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  output logic                                ready_o,
  input  logic signed [P:0]                   err_i,
  input  logic signed [I-1:0]                 integ_i,
  input  logic signed [P+1:0]                 delta_i,
  input  pmc_pkg::result_ctl_t                ctl_i,
  input  logic [pmc_pkg::GAIN_BITS-1:0]       prop_gain_i,
  input  logic [pmc_pkg::GAIN_BITS-1:0]       integ_gain_i,
  input  logic [pmc_pkg::GAIN_BITS-1:0]       deriv_gain_i,
  output logic                                valid_o,
  input  logic                                ready_i,
  output logic signed [pmc_pkg::SUM_BITS-1:0] p_o,
  output logic signed [pmc_pkg::SUM_BITS-1:0] i_o,
  output logic signed [pmc_pkg::SUM_BITS-1:0] d_o,
  output pmc_pkg::result_ctl_t                ctl_o
);
  import pmc_pkg::*;

  logic                       valid_q;
  logic signed [SUM_BITS-1:0] p_d, i_d, d_d;
  logic signed [SUM_BITS-1:0] p_q, i_q, d_q;
  result_ctl_t                ctl_q;

  assign ready_o = !valid_q || ready_i;

  pmc_satmul #(.W(P + 1)) u_prop (
    .gain_i (prop_gain_i),
    .oper_i (err_i),
    .prod_o (p_d)
  );

  pmc_satmul #(.W(I)) u_integ (
    .gain_i (integ_gain_i),
    .oper_i (integ_i),
    .prod_o (i_d)
  );

  pmc_satmul #(.W(P + 2)) u_deriv (
    .gain_i (deriv_gain_i),
    .oper_i (delta_i),
    .prod_o (d_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      p_q   <= p_d;
      i_q   <= i_d;
      d_q   <= d_d;
      ctl_q <= ctl_i;
    end
  end

  assign valid_o = valid_q;
  assign p_o     = p_q;
  assign i_o     = i_q;
  assign d_o     = d_q;
  assign ctl_o   = ctl_q;

endmodule

FILE: src/pmc_sum.sv
// Sum stages and output register: two clamped adds, Q.16 truncation, power clamp.
module pmc_sum #(
  parameter int F = pmc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  logic signed [pmc_pkg::SUM_BITS-1:0]  p_i,
  input  logic signed [pmc_pkg::SUM_BITS-1:0]  i_i,
  input  logic signed [pmc_pkg::SUM_BITS-1:0]  d_i,
  input  pmc_pkg::result_ctl_t                 ctl_i,
  input  logic [pmc_pkg::LIMIT_BITS-1:0]       power_limit_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output logic signed [pmc_pkg::POWER_BITS-1:0] power_o,
  output pmc_pkg::result_ctl_t                 ctl_o
);
  import pmc_pkg::*;

  logic                         va_q, vb_q, vc_q;
  logic                         rdy_a, rdy_b, rdy_c;
  logic signed [SUM_BITS-1:0]   s1_q, d_q, s2_q;
  result_ctl_t                  ctl_a_q, ctl_b_q, ctl_c_q;
  logic signed [POWER_BITS-1:0] power_q, power_d;
  logic [SUM_BITS-1:0]          mag_full, shifted;
  logic [LIMIT_BITS-1:0]        mag;

  assign rdy_c   = !vc_q || ready_i;
  assign rdy_b   = !vb_q || rdy_c;
  assign rdy_a   = !va_q || rdy_b;
  assign ready_o = rdy_a;

  // Magnitude, drop the fraction bits, cap at the limit, restore the sign
  always_comb begin
    mag_full = s2_q[SUM_BITS-1] ? SUM_BITS'(-s2_q) : SUM_BITS'(s2_q);
    shifted  = mag_full >> F;
    mag      = (shifted > SUM_BITS'(power_limit_i)) ? power_limit_i : shifted[LIMIT_BITS-1:0];
    power_d  = s2_q[SUM_BITS-1] ? -$signed(POWER_BITS'(mag)) : $signed(POWER_BITS'(mag));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else begin
      if (rdy_a) begin
        va_q <= valid_i;
      end
      if (rdy_b) begin
        vb_q <= va_q;
      end
      if (rdy_c) begin
        vc_q <= vb_q;
      end
    end
  end

  // Proportional plus integral, then derivative, each clamped
  always_ff @(posedge clk_i) begin
    if (valid_i && rdy_a) begin
      s1_q    <= clamp_big((SUM_BITS+1)'(p_i) + (SUM_BITS+1)'(i_i));
      d_q     <= d_i;
      ctl_a_q <= ctl_i;
    end
    if (va_q && rdy_b) begin
      s2_q    <= clamp_big((SUM_BITS+1)'(s1_q) + (SUM_BITS+1)'(d_q));
      ctl_b_q <= ctl_a_q;
    end
    if (vb_q && rdy_c) begin
      power_q <= power_d;
      ctl_c_q <= ctl_b_q;
    end
  end

  assign valid_o = vc_q;
  assign power_o = power_q;
  assign ctl_o   = ctl_c_q;

endmodule

FILE: src/pid_position_move_controller_top.sv
// Top level of the PID position move controller with integral zone.
//
// Usage: requests enter on the s_axis channel. tuser selects the request kind
// (0 = start a move toward the target, 1 = control tick with a measured
// position); tdata carries target (low field) and position (next field).
// Every request yields exactly one result on m_axis: tdata is the signed
// drive power, tuser the status (0 running, 1 reached band, 2 timed out,
// 3 idle) and tlast marks the tick that ends the move.
// Gains, integral zone, exit band, power limit and tick length must be
// written over the cfg channel (always ready) while no request is in flight;
// the block itself does not enforce this. A result passes through the front,
// multiply, two sum stages and output register. Throughput: one request
// per cycle while the receiver keeps up; move state is updated in the front
// stage so a tick may follow any request in the next cycle.
// Reset clears the move state (idle) and loads the default register values.
// When the receiver stalls, results stay in the pipeline registers; bubbles
// fill first and s_axis_tready drops only once every stage holds a result.
module pid_position_move_controller_top #(
  parameter int POSITION_BITS      = pmc_pkg::POSITION_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = pmc_pkg::GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_BITS      = pmc_pkg::INTEGRAL_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // target, position
  input  logic [((2*POSITION_BITS+7)/8)*8-1:0]  s_axis_tdata,
  // opcode
  input  logic                                  s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // drive_power
  output logic [pmc_pkg::POWER_BITS-1:0]        m_axis_tdata,
  // status
  output logic [pmc_pkg::STATUS_BITS-1:0]       m_axis_tuser,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [pmc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr_i,
  input  logic [pmc_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);
  import pmc_pkg::*;

  localparam int P = POSITION_BITS;
  localparam int I = INTEGRAL_BITS;

  // Configuration registers
  logic [GAIN_BITS-1:0]  prop_gain_q, integ_gain_q, deriv_gain_q;
  logic [ZONE_BITS-1:0]  integral_zone_q;
  logic [BAND_BITS-1:0]  exit_band_q;
  logic [LIMIT_BITS-1:0] power_limit_q;
  logic [TICK_BITS-1:0]  tick_ms_q;

  // Pipeline links
  logic                       fr_valid, fr_ready;
  logic signed [P:0]          fr_err;
  logic signed [I-1:0]        fr_integ;
  logic signed [P+1:0]        fr_delta;
  result_ctl_t                fr_ctl;
  logic                       mu_valid, mu_ready;
  logic signed [SUM_BITS-1:0] mu_p, mu_i, mu_d;
  result_ctl_t                mu_ctl;
  logic signed [POWER_BITS-1:0] out_power;
  result_ctl_t                out_ctl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q     <= PROP_GAIN_RST;
      integ_gain_q    <= INTEG_GAIN_RST;
      deriv_gain_q    <= DERIV_GAIN_RST;
      integral_zone_q <= ZONE_RST;
      exit_band_q     <= BAND_RST;
      power_limit_q   <= LIMIT_RST;
      tick_ms_q       <= TICK_MS_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_PROP_GAIN:  prop_gain_q     <= cfg_data_i[GAIN_BITS-1:0];
        CFG_INTEG_GAIN: integ_gain_q    <= cfg_data_i[GAIN_BITS-1:0];
        CFG_DERIV_GAIN: deriv_gain_q    <= cfg_data_i[GAIN_BITS-1:0];
        CFG_ZONE:       integral_zone_q <= cfg_data_i[ZONE_BITS-1:0];
        CFG_BAND:       exit_band_q     <= cfg_data_i[BAND_BITS-1:0];
        CFG_LIMIT:      power_limit_q   <= cfg_data_i[LIMIT_BITS-1:0];
        CFG_TICK_MS:    tick_ms_q       <= cfg_data_i[TICK_BITS-1:0];
        default: ;
      endcase
    end
  end

  pmc_front #(.P(P), .I(I)) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (s_axis_tvalid),
    .ready_o         (s_axis_tready),
    .opcode_i        (opcode_e'(s_axis_tuser)),
    .target_i        ($signed(s_axis_tdata[P-1:0])),
    .position_i      ($signed(s_axis_tdata[2*P-1:P])),
    .integral_zone_i (integral_zone_q),
    .exit_band_i     (exit_band_q),
    .tick_ms_i       (tick_ms_q),
    .valid_o         (fr_valid),
    .ready_i         (fr_ready),
    .err_o           (fr_err),
    .integ_o         (fr_integ),
    .delta_o         (fr_delta),
    .ctl_o           (fr_ctl)
  );

  pmc_mult #(.P(P), .I(I)) u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (fr_valid),
    .ready_o      (fr_ready),
    .err_i        (fr_err),
    .integ_i      (fr_integ),
    .delta_i      (fr_delta),
    .ctl_i        (fr_ctl),
    .prop_gain_i  (prop_gain_q),
    .integ_gain_i (integ_gain_q),
    .deriv_gain_i (deriv_gain_q),
    .valid_o      (mu_valid),
    .ready_i      (mu_ready),
    .p_o          (mu_p),
    .i_o          (mu_i),
    .d_o          (mu_d),
    .ctl_o        (mu_ctl)
  );

  pmc_sum #(.F(GAIN_FRACTION_BITS)) u_sum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (mu_valid),
    .ready_o       (mu_ready),
    .p_i           (mu_p),
    .i_i           (mu_i),
    .d_i           (mu_d),
    .ctl_i         (mu_ctl),
    .power_limit_i (power_limit_q),
    .valid_o       (m_axis_tvalid),
    .ready_i       (m_axis_tready),
    .power_o       (out_power),
    .ctl_o         (out_ctl)
  );

  assign m_axis_tdata = out_power;
  assign m_axis_tuser = out_ctl.status;
  assign m_axis_tlast = out_ctl.done;

  // A move only ends with a band or timeout status
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> (m_axis_tuser == ST_REACHED || m_axis_tuser == ST_TIMEOUT))
    else $error("move end without reached or timeout status");

  // Idle ticks drive nothing and end nothing
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ST_IDLE |-> m_axis_tdata == '0 && !m_axis_tlast)
    else $error("idle result with nonzero power or end flag");

  // Output power stays within the configured limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) <= $signed({1'b0, power_limit_q}))
                   && ($signed(m_axis_tdata) >= -$signed({1'b0, power_limit_q})))
    else $error("drive power beyond limit");

endmodule
